// File: hw/rtl/bt_pkg.sv
// Package for the bearing triangulation block: widths, stage map, constants, types.
// No dependencies; every other file in hw/rtl uses it by scoped name.
package bt_pkg;

   // Field widths
   localparam int COORD_W    = 32;
   localparam int ANGLE_BITS = 16;
   localparam int TRIG_W     = 31;  // sine/cosine magnitude, Q30, at most 1.0

   localparam logic [TRIG_W-1:0] Q30_ONE = 31'h4000_0000;
   localparam logic [31:0]       PI_Q30  = 32'd3373259426;

   // Angle codes: ANGLE_PI is pi, ANGLE_HALF is pi/2
   localparam logic [ANGLE_BITS:0] ANGLE_PI   = (ANGLE_BITS+1)'(1) << ANGLE_BITS;
   localparam logic [ANGLE_BITS:0] ANGLE_HALF = ANGLE_PI >> 1;

   // Horner evaluation of the sine series, divisors as reciprocals
   localparam int HORNER_STEPS = 5;
   localparam int RECIP_SHIFT  = 40;
   localparam int RECIP_W      = 38;
   localparam logic [RECIP_W-1:0] HORNER_RECIP [HORNER_STEPS] = '{
      RECIP_W'((72'd1 << RECIP_SHIFT) / 72'd110 + 72'd1),
      RECIP_W'((72'd1 << RECIP_SHIFT) / 72'd72 + 72'd1),
      RECIP_W'((72'd1 << RECIP_SHIFT) / 72'd42 + 72'd1),
      RECIP_W'((72'd1 << RECIP_SHIFT) / 72'd20 + 72'd1),
      RECIP_W'((72'd1 << RECIP_SHIFT) / 72'd6 + 72'd1)
   };
   localparam int SINE_LAT = 3 + 2 * HORNER_STEPS;

   // Stage map of the main pipeline (register index)
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 64;
   localparam int ST_SIDE    = 1;                       // differences, angle folding
   localparam int ST_SQ      = ST_SIDE + 1;             // squares
   localparam int ST_SUM     = ST_SQ + 1;               // sum of squares
   localparam int ST_ROOT    = ST_SUM + SQRT_STEPS;     // last root step
   localparam int ST_NUM     = ST_ROOT + 1;             // baseline times sin(beta)
   localparam int ST_QUO     = ST_NUM + DIV_STEPS;      // last divide step
   localparam int ST_PROD    = ST_QUO + 1;              // partial products
   localparam int ST_MAG     = ST_PROD + 1;             // offset magnitudes
   localparam int LAST_STAGE = ST_MAG;
   localparam int TAP_BG     = ST_ROOT - SINE_LAT;      // sine units for beta, gamma
   localparam int TAP_A      = ST_QUO - SINE_LAT;       // sine units for alpha

   localparam logic [33:0] OFFSET_CAP = 34'h2_0000_0000;
   localparam int FIFO_DEPTH = 2;

   // Result status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_NO_TRI = 2'd1;
   localparam logic [1:0] STATUS_SAT    = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic                      no_tri;
      logic                      cos_neg;
      logic                      sh;
      logic [ANGLE_BITS-1:0]     q_sin_a;
      logic [ANGLE_BITS-1:0]     q_cos_a;
      logic [ANGLE_BITS-1:0]     q_beta;
      logic [ANGLE_BITS-1:0]     q_gamma;
   } side_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_c_x;
      logic signed [COORD_W-1:0] point_c_y;
      logic [1:0]                fix_status;
   } rsp_type;

endpackage

// File: hw/rtl/bt_if.sv
// Valid/ready channel interfaces for the bearing triangulation block.
// Depends on bt_pkg for field widths.
interface bt_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [bt_pkg::COORD_W-1:0] point_a_x;
   logic signed [bt_pkg::COORD_W-1:0] point_a_y;
   logic signed [bt_pkg::COORD_W-1:0] point_b_x;
   logic signed [bt_pkg::COORD_W-1:0] point_b_y;
   logic [bt_pkg::ANGLE_BITS-1:0]     angle_at_a;
   logic [bt_pkg::ANGLE_BITS-1:0]     angle_at_b;

   modport source (output valid, point_a_x, point_a_y, point_b_x, point_b_y,
                   angle_at_a, angle_at_b, input ready);
   modport sink   (input valid, point_a_x, point_a_y, point_b_x, point_b_y,
                   angle_at_a, angle_at_b, output ready);
endinterface

interface bt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [bt_pkg::COORD_W-1:0] point_c_x;
   logic signed [bt_pkg::COORD_W-1:0] point_c_y;
   logic [1:0]                        fix_status;

   modport source (output valid, point_c_x, point_c_y, fix_status, input ready);
   modport sink   (input valid, point_c_x, point_c_y, fix_status, output ready);
endinterface

// File: hw/rtl/bt_sine.sv
// Pipelined first-quadrant sine: angle code in [0, pi/2] to Q30, Horner Taylor series.
// Depends on bt_pkg; the pipeline advances on en.
module bt_sine (
   input  logic                          clock,
   input  logic                          en,
   input  logic [bt_pkg::ANGLE_BITS-1:0] angle,
   output logic [bt_pkg::TRIG_W-1:0]     sine
);

   logic [30:0] x_ff;
   logic [30:0] xs_ff;
   logic [31:0] x2s_ff;
   logic [30:0] xa_ff  [bt_pkg::HORNER_STEPS];
   logic [31:0] x2a_ff [bt_pkg::HORNER_STEPS];
   logic [31:0] pa_ff  [bt_pkg::HORNER_STEPS];
   logic [30:0] xb_ff  [bt_pkg::HORNER_STEPS];
   logic [31:0] x2b_ff [bt_pkg::HORNER_STEPS];
   logic [29:0] qb_ff  [bt_pkg::HORNER_STEPS];
   logic [bt_pkg::TRIG_W-1:0] sine_ff;

   logic [bt_pkg::ANGLE_BITS+31:0] rad_prod;
   logic [61:0]                    sq_prod;
   logic [bt_pkg::TRIG_W-1:0]      t_last;
   logic [61:0]                    s_prod;
   logic [bt_pkg::TRIG_W-1:0]      sine_in;

   // Convert to radians in Q30, then square
   assign rad_prod = (bt_pkg::ANGLE_BITS+32)'(angle) * (bt_pkg::ANGLE_BITS+32)'(bt_pkg::PI_Q30);
   assign sq_prod  = 62'(x_ff) * 62'(x_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff   <= rad_prod[bt_pkg::ANGLE_BITS+30:bt_pkg::ANGLE_BITS];
         xs_ff  <= x_ff;
         x2s_ff <= sq_prod[61:30];
      end
   end

   // Horner steps: multiply by x^2, then divide by a constant through its reciprocal
   for (genvar j = 0; j < bt_pkg::HORNER_STEPS; j++) begin : g_step
      logic [30:0]                      x_cur;
      logic [31:0]                      x2_cur;
      logic [bt_pkg::TRIG_W-1:0]        t_cur;
      logic [62:0]                      p_prod;
      logic [bt_pkg::RECIP_W+31:0]      q_prod;

      if (j == 0) begin : g_first
         assign x_cur  = xs_ff;
         assign x2_cur = x2s_ff;
         assign t_cur  = bt_pkg::Q30_ONE;
      end else begin : g_next
         assign x_cur  = xb_ff[j-1];
         assign x2_cur = x2b_ff[j-1];
         assign t_cur  = bt_pkg::Q30_ONE - bt_pkg::TRIG_W'(qb_ff[j-1]);
      end

      assign p_prod = 63'(x2_cur) * 63'(t_cur);
      assign q_prod = (bt_pkg::RECIP_W+32)'(pa_ff[j])
                      * (bt_pkg::RECIP_W+32)'(bt_pkg::HORNER_RECIP[j]);

      always_ff @(posedge clock) begin
         if (en) begin
            xa_ff[j]  <= x_cur;
            x2a_ff[j] <= x2_cur;
            pa_ff[j]  <= p_prod[61:30];
            xb_ff[j]  <= xa_ff[j];
            x2b_ff[j] <= x2a_ff[j];
            qb_ff[j]  <= q_prod[bt_pkg::RECIP_SHIFT+29:bt_pkg::RECIP_SHIFT];
         end
      end
   end

   // Final multiply by x, clamp to one
   assign t_last  = bt_pkg::Q30_ONE - bt_pkg::TRIG_W'(qb_ff[bt_pkg::HORNER_STEPS-1]);
   assign s_prod  = 62'(xb_ff[bt_pkg::HORNER_STEPS-1]) * 62'(t_last);
   assign sine_in = (s_prod[61:30] > 32'(bt_pkg::Q30_ONE)) ? bt_pkg::Q30_ONE
                                                          : s_prod[60:30];

   always_ff @(posedge clock) begin
      if (en) begin
         sine_ff <= sine_in;
      end
   end

   assign sine = sine_ff;

endmodule

// File: hw/rtl/bt_div.sv
// Pipelined restoring divider, one quotient bit per stage: 64-bit by 31-bit unsigned.
// Depends on bt_pkg; the pipeline advances on en.
module bt_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [63:0]                   num,
   input  logic [bt_pkg::TRIG_W-1:0]     den,
   output logic [63:0]                   quo
);

   logic [bt_pkg::TRIG_W-1:0] rem_ff [bt_pkg::DIV_STEPS];
   logic [bt_pkg::TRIG_W-1:0] den_ff [bt_pkg::DIV_STEPS];
   logic [63:0]               nq_ff  [bt_pkg::DIV_STEPS];

   for (genvar k = 0; k < bt_pkg::DIV_STEPS; k++) begin : g_step
      logic [bt_pkg::TRIG_W-1:0] rem_cur;
      logic [bt_pkg::TRIG_W-1:0] den_cur;
      logic [63:0]               nq_cur;
      logic [bt_pkg::TRIG_W:0]   trial;
      logic                      take;
      logic [bt_pkg::TRIG_W-1:0] rem_in;

      if (k == 0) begin : g_first
         assign rem_cur = '0;
         assign den_cur = den;
         assign nq_cur  = num;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign den_cur = den_ff[k-1];
         assign nq_cur  = nq_ff[k-1];
      end

      // Shift in the next numerator bit, subtract when it fits
      assign trial  = {rem_cur, nq_cur[63]};
      assign take   = trial >= {1'b0, den_cur};
      assign rem_in = take ? bt_pkg::TRIG_W'(trial - {1'b0, den_cur})
                           : bt_pkg::TRIG_W'(trial);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_cur;
            nq_ff[k]  <= {nq_cur[62:0], take};
         end
      end
   end

   assign quo = nq_ff[bt_pkg::DIV_STEPS-1];

endmodule

// File: hw/rtl/bearing_triangulation.sv
// Bearing triangulation top level: law-of-sines fix from two points and two angles.
// Depends on bt_pkg, bt_if, bt_sine and bt_div.
//
// Takes one item per clock cycle while req_chan.ready is high and returns each
// point C in order of acceptance. The depth comes from the 32-step square root of the
// baseline and the 64-step divider that forms AC = |AB| sin(beta) / sin(gamma);
// four 13-stage sine units run beside them. A two-entry output buffer holds
// finished results, so the pipeline keeps taking items while one result waits;
// req_chan.ready drops only when both entries are full. Status 1 (no triangle)
// returns C = 0, status 2 flags a saturated coordinate. There is no
// configuration and reset only clears the pipeline valid bits and the buffer.
module bearing_triangulation (
   input  logic      clock,
   input  logic      reset,
   bt_req_if.sink    req_chan,
   bt_rsp_if.source  rsp_chan
);

   // Cap an offset magnitude: floor(a * b / 2^30) from hi and lo partial products
   function automatic logic [33:0] offset_mag(input logic [62:0] hi, input logic [62:0] lo);
      logic [62:0] r;
      begin
         r = {hi[60:0], 2'b00} + 63'(lo[62:30]);
         if (hi[62:60] != 3'd0 || r > 63'(bt_pkg::OFFSET_CAP)) begin
            offset_mag = bt_pkg::OFFSET_CAP;
         end else begin
            offset_mag = r[33:0];
         end
      end
   endfunction

   logic en;
   logic valid_ff [0:bt_pkg::LAST_STAGE];

   // Entry registers
   logic signed [31:0] ax0_ff, ay0_ff, bx0_ff, by0_ff;
   logic [bt_pkg::ANGLE_BITS-1:0] alpha0_ff, beta0_ff;

   bt_pkg::side_type side_ff [bt_pkg::ST_SIDE:bt_pkg::LAST_STAGE];
   bt_pkg::side_type side_in;

   logic [30:0] adx_ff, ady_ff, adx_in, ady_in;
   logic [61:0] sqx_ff, sqy_ff;
   logic [62:0] sum_ff;
   logic [62:0] root_v_ff [bt_pkg::SQRT_STEPS];
   logic [63:0] root_r_ff [bt_pkg::SQRT_STEPS];
   logic [63:0] num_ff, num_in;
   logic [bt_pkg::TRIG_W-1:0] den_ff, den_in;
   logic [62:0] hix_ff, lox_ff, hiy_ff, loy_ff;
   logic [33:0] mx_ff, my_ff;

   logic signed [32:0] dx, dy;
   logic [31:0] adx, ady;
   logic [bt_pkg::ANGLE_BITS:0] gsum, gamma, beta_w, alpha_w;
   logic [32:0] dab;
   logic [bt_pkg::TRIG_W-1:0] sin_b, sin_g, sin_a, cos_a;
   logic [63:0] quo;

   bt_pkg::rsp_type res, head_ff, tail_ff, head_in, tail_in;
   logic signed [35:0] offx, offy, cx, cy;
   logic sat_x, sat_y;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   // Advance the whole pipeline while the output buffer has room
   assign en             = cnt_ff != 2'(bt_pkg::FIFO_DEPTH);
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= bt_pkg::LAST_STAGE; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= req_chan.valid;
         for (int k = 1; k <= bt_pkg::LAST_STAGE; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   // Capture the item
   always_ff @(posedge clock) begin
      if (en) begin
         ax0_ff    <= req_chan.point_a_x;
         ay0_ff    <= req_chan.point_a_y;
         bx0_ff    <= req_chan.point_b_x;
         by0_ff    <= req_chan.point_b_y;
         alpha0_ff <= req_chan.angle_at_a;
         beta0_ff  <= req_chan.angle_at_b;
      end
   end

   // Baseline differences and angle folding into the first quadrant
   always_comb begin
      dx      = {bx0_ff[31], bx0_ff} - {ax0_ff[31], ax0_ff};
      dy      = {by0_ff[31], by0_ff} - {ay0_ff[31], ay0_ff};
      adx     = dx[32] ? 32'(-dx) : 32'(dx);
      ady     = dy[32] ? 32'(-dy) : 32'(dy);
      side_in.sh = adx[31] | ady[31];
      adx_in  = side_in.sh ? adx[31:1] : adx[30:0];
      ady_in  = side_in.sh ? ady[31:1] : ady[30:0];

      gsum    = {1'b0, alpha0_ff} + {1'b0, beta0_ff};
      gamma   = bt_pkg::ANGLE_PI - gsum;
      beta_w  = {1'b0, beta0_ff};
      alpha_w = {1'b0, alpha0_ff};

      side_in.ax      = ax0_ff;
      side_in.ay      = ay0_ff;
      side_in.no_tri  = gsum[bt_pkg::ANGLE_BITS];
      side_in.q_gamma = (gsum >= bt_pkg::ANGLE_HALF) ? gamma[bt_pkg::ANGLE_BITS-1:0]
                                                     : gsum[bt_pkg::ANGLE_BITS-1:0];
      side_in.q_beta  = (beta_w <= bt_pkg::ANGLE_HALF) ? beta0_ff
                        : bt_pkg::ANGLE_BITS'(bt_pkg::ANGLE_PI - beta_w);
      side_in.q_sin_a = (alpha_w <= bt_pkg::ANGLE_HALF) ? alpha0_ff
                        : bt_pkg::ANGLE_BITS'(bt_pkg::ANGLE_PI - alpha_w);
      side_in.cos_neg = alpha_w > bt_pkg::ANGLE_HALF;
      side_in.q_cos_a = side_in.cos_neg
                        ? bt_pkg::ANGLE_BITS'(alpha_w - bt_pkg::ANGLE_HALF)
                        : bt_pkg::ANGLE_BITS'(bt_pkg::ANGLE_HALF - alpha_w);
   end

   // Carry the side data along with each item
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[bt_pkg::ST_SIDE] <= side_in;
         for (int k = bt_pkg::ST_SIDE + 1; k <= bt_pkg::LAST_STAGE; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Squares, then their sum
   always_ff @(posedge clock) begin
      if (en) begin
         adx_ff <= adx_in;
         ady_ff <= ady_in;
         sqx_ff <= 62'(adx_ff) * 62'(adx_ff);
         sqy_ff <= 62'(ady_ff) * 62'(ady_ff);
         sum_ff <= 63'(sqx_ff) + 63'(sqy_ff);
      end
   end

   // Integer square root, one result bit per stage
   for (genvar i = 0; i < bt_pkg::SQRT_STEPS; i++) begin : g_root
      localparam logic [63:0] STEP_MASK = 64'd1 << (62 - 2 * i);
      logic [62:0] v_cur;
      logic [63:0] r_cur;
      logic [63:0] trial;
      logic [62:0] root_v_in;
      logic [63:0] root_r_in;

      if (i == 0) begin : g_first
         assign v_cur = sum_ff;
         assign r_cur = '0;
      end else begin : g_next
         assign v_cur = root_v_ff[i-1];
         assign r_cur = root_r_ff[i-1];
      end

      always_comb begin
         trial = r_cur + STEP_MASK;
         if ({1'b0, v_cur} >= trial) begin
            root_v_in = 63'({1'b0, v_cur} - trial);
            root_r_in = (r_cur >> 1) + STEP_MASK;
         end else begin
            root_v_in = v_cur;
            root_r_in = r_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            root_v_ff[i] <= root_v_in;
            root_r_ff[i] <= root_r_in;
         end
      end
   end

   // Sine units, started so their results meet the item where they are used
   bt_sine u_sin_b (
      .clock (clock), .en (en), .angle (side_ff[bt_pkg::TAP_BG].q_beta), .sine (sin_b)
   );
   bt_sine u_sin_g (
      .clock (clock), .en (en), .angle (side_ff[bt_pkg::TAP_BG].q_gamma), .sine (sin_g)
   );
   bt_sine u_sin_a (
      .clock (clock), .en (en), .angle (side_ff[bt_pkg::TAP_A].q_sin_a), .sine (sin_a)
   );
   bt_sine u_cos_a (
      .clock (clock), .en (en), .angle (side_ff[bt_pkg::TAP_A].q_cos_a), .sine (cos_a)
   );

   // Baseline times sin(beta); a zero sin(gamma) forces a zero range
   always_comb begin
      dab = side_ff[bt_pkg::ST_ROOT].sh ? {root_r_ff[bt_pkg::SQRT_STEPS-1][31:0], 1'b0}
                                        : {1'b0, root_r_ff[bt_pkg::SQRT_STEPS-1][31:0]};
      if (sin_g == '0) begin
         num_in = '0;
         den_in = bt_pkg::TRIG_W'(1);
      end else begin
         num_in = 64'(dab) * 64'(sin_b);
         den_in = sin_g;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   bt_div u_div (
      .clock (clock), .en (en), .num (num_ff), .den (den_ff), .quo (quo)
   );

   // Partial products of range times direction, then capped magnitudes
   always_ff @(posedge clock) begin
      if (en) begin
         lox_ff <= 63'(quo[31:0]) * 63'(cos_a);
         hix_ff <= 63'(quo[63:32]) * 63'(cos_a);
         loy_ff <= 63'(quo[31:0]) * 63'(sin_a);
         hiy_ff <= 63'(quo[63:32]) * 63'(sin_a);
         mx_ff  <= offset_mag(hix_ff, lox_ff);
         my_ff  <= offset_mag(hiy_ff, loy_ff);
      end
   end

   // Add the offset to A, saturate, and form the status
   always_comb begin
      offx  = side_ff[bt_pkg::LAST_STAGE].cos_neg ? -36'(mx_ff) : 36'(mx_ff);
      offy  = 36'(my_ff);
      cx    = 36'(side_ff[bt_pkg::LAST_STAGE].ax) + offx;
      cy    = 36'(side_ff[bt_pkg::LAST_STAGE].ay) + offy;
      sat_x = (cx > 36'sd2147483647) || (cx < -36'sd2147483648);
      sat_y = (cy > 36'sd2147483647) || (cy < -36'sd2147483648);

      if (side_ff[bt_pkg::LAST_STAGE].no_tri) begin
         res.point_c_x  = '0;
         res.point_c_y  = '0;
         res.fix_status = bt_pkg::STATUS_NO_TRI;
      end else begin
         res.point_c_x  = sat_x ? (cx[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : cx[31:0];
         res.point_c_y  = sat_y ? (cy[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : cy[31:0];
         res.fix_status = (sat_x || sat_y) ? bt_pkg::STATUS_SAT : bt_pkg::STATUS_OK;
      end
   end

   // Two-entry output buffer
   assign push = en && valid_ff[bt_pkg::LAST_STAGE];
   assign pop  = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      cnt_in  = cnt_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      case (cnt_ff)
         2'd0: begin
            if (push) begin
               head_in = res;
               cnt_in  = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_in = res;
            end else if (push) begin
               tail_in = res;
               cnt_in  = 2'd2;
            end else if (pop) begin
               cnt_in  = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               head_in = tail_ff;
               cnt_in  = 2'd1;
            end
         end
         default: begin
            cnt_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_chan.valid      = cnt_ff != 2'd0;
   assign rsp_chan.point_c_x  = head_ff.point_c_x;
   assign rsp_chan.point_c_y  = head_ff.point_c_y;
   assign rsp_chan.fix_status = head_ff.fix_status;

endmodule

// File: hw/rtl/bt_checker.sv
// Port-level checks for the bearing triangulation block, bound to its top level.
// Depends on bt_pkg and bt_if.
module bt_checker (
   input logic      clock,
   input logic      reset,
   bt_req_if.sink   req_chan,
   bt_rsp_if.source rsp_chan
);

   // Hold a waiting result item and its payload until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid
         && $stable(rsp_chan.point_c_x) && $stable(rsp_chan.point_c_y)
         && $stable(rsp_chan.fix_status))
      else $error("result item changed or dropped while stalled");

   // Status carries only defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.fix_status == bt_pkg::STATUS_OK
         || rsp_chan.fix_status == bt_pkg::STATUS_NO_TRI
         || rsp_chan.fix_status == bt_pkg::STATUS_SAT))
      else $error("undefined fix status");

   // No triangle returns the origin
   a_no_tri_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.fix_status == bt_pkg::STATUS_NO_TRI
         |-> rsp_chan.point_c_x == '0 && rsp_chan.point_c_y == '0)
      else $error("no-triangle item with nonzero point");

   // Drop input ready only when results are backed up at the output
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      $fell(req_chan.ready) |-> rsp_chan.valid && $past(rsp_chan.valid))
      else $error("input stalled with no result waiting");

endmodule

bind bearing_triangulation bt_checker u_bt_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);

// File: bench/bt_tb_if.sv
`timescale 1ns / 100ps
// Testbench types: the request item packed into one struct for driving and prediction.
// Depends on bt_pkg; the channels themselves come from hw/rtl/bt_if.sv.
package bt_tb_types;
   import bt_pkg::*;

   typedef struct packed {
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
      logic [ANGLE_BITS-1:0]     alpha;
      logic [ANGLE_BITS-1:0]     beta;
   } fix_req_type;
endpackage

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Testbench for bearing_triangulation: directed and random point pairs and angles,
// each fix predicted in-bench and compared in order. Depends on bt_pkg, bt_if, bt_tb_types.
module testbench;
   import bt_pkg::*;
   import bt_tb_types::*;

   localparam int LATENCY    = 103;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bt_req_if req_chan ();
   bt_rsp_if rsp_chan ();

   bearing_triangulation u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #6 clock = ~clock;

   rsp_type fix_queue[$];
   int      mismatch_count = 0;
   int      idle_cycles    = 0;
   int      long_hold      = 0;
   bit      rx_stall_on    = 1'b1;

   // Q30 sine on the first quadrant, Horner series through x^11
   function automatic logic [63:0] quadrant_sine(logic [63:0] a);
      logic [63:0] x, x2, t, s;
      x  = (a * 64'd3373259426) >> ANGLE_BITS;
      x2 = (x * x) >> 30;
      t  = 64'd1 << 30;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 110;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 72;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 42;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      return (s > (64'd1 << 30)) ? (64'd1 << 30) : s;
   endfunction

   function automatic logic [63:0] angle_sine(logic [63:0] a);
      logic [63:0] full;
      full = 64'd1 << ANGLE_BITS;
      return (a <= full / 2) ? quadrant_sine(a) : quadrant_sine(full - a);
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] scale_by_trig(logic [63:0] a, logic [63:0] b);
      logic [63:0] lo, hi, r;
      lo = a[31:0] * b;
      hi = (a >> 32) * b;
      if (hi >= (64'd1 << 60)) return 64'(OFFSET_CAP);
      r = (hi << 2) + (lo >> 30);
      return (r > 64'(OFFSET_CAP)) ? 64'(OFFSET_CAP) : r;
   endfunction

   function automatic logic signed [63:0] clamp_coord(logic signed [63:0] v,
                                                     inout bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Predict point C and status for one request
   function automatic rsp_type predict_fix(fix_req_type r);
      rsp_type     o;
      logic signed [63:0] ax, ay, dx, dy, gam, cos_a, offx, offy;
      logic [63:0] adx, ady, dab, sin_g, sin_b, dac, sin_a, mx, my, half;
      bit          sh, sat;
      ax   = r.ax;
      ay   = r.ay;
      half = 64'd1 << (ANGLE_BITS - 1);
      gam  = (64'sd1 << ANGLE_BITS) - r.alpha - r.beta;
      if (gam <= 0) begin
         o.point_c_x  = '0;
         o.point_c_y  = '0;
         o.fix_status = STATUS_NO_TRI;
         return o;
      end
      dx  = 64'(r.bx) - ax;
      dy  = 64'(r.by) - ay;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      sh  = (adx >= (64'd1 << 31)) || (ady >= (64'd1 << 31));
      adx = adx >> sh;
      ady = ady >> sh;
      dab = root_floor(adx * adx + ady * ady) << sh;
      sin_g = angle_sine(gam);
      sin_b = angle_sine(64'(r.beta));
      dac   = (sin_g != 0) ? (dab * sin_b) / sin_g : 0;
      if (r.alpha <= half) cos_a = quadrant_sine(half - r.alpha);
      else cos_a = -quadrant_sine(64'(r.alpha) - half);
      sin_a = angle_sine(64'(r.alpha));
      mx    = scale_by_trig(dac, (cos_a < 0) ? -cos_a : cos_a);
      my    = scale_by_trig(dac, sin_a);
      offx  = (cos_a < 0) ? -$signed(mx) : $signed(mx);
      offy  = $signed(my);
      sat   = 1'b0;
      o.point_c_x  = 32'(clamp_coord(ax + offx, sat));
      o.point_c_y  = 32'(clamp_coord(ay + offy, sat));
      o.fix_status = sat ? STATUS_SAT : STATUS_OK;
      return o;
   endfunction

   // Drive one item and hold it until accepted
   task automatic send_fix(fix_req_type r);
      req_chan.valid      <= 1'b1;
      req_chan.point_a_x  <= r.ax;
      req_chan.point_a_y  <= r.ay;
      req_chan.point_b_x  <= r.bx;
      req_chan.point_b_y  <= r.by;
      req_chan.angle_at_a <= r.alpha;
      req_chan.angle_at_b <= r.beta;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      fix_queue = {fix_queue, predict_fix(r)};
   endtask

   // Drop valid for a random gap, or keep it up for the burst
   task automatic sender_gap(int gap);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_fixes();
      req_chan.valid <= 1'b0;
      while (fix_queue.size() != 0) @(posedge clock);
   endtask

   function automatic fix_req_type random_fix(bit narrow);
      fix_req_type r;
      r.ax = $urandom;
      r.ay = $urandom;
      if (narrow) begin
         r.bx = r.ax + $signed($urandom_range(0, 2000000)) - 1000000;
         r.by = r.ay + $signed($urandom_range(0, 2000000)) - 1000000;
         r.ax = $signed(r.ax) >>> 4;
         r.ay = $signed(r.ay) >>> 4;
         r.bx = $signed(r.bx) >>> 4;
         r.by = $signed(r.by) >>> 4;
         r.alpha = 16'($urandom_range(1, 60000));
         r.beta  = 16'($urandom_range(1, 65535 - r.alpha));
      end else begin
         r.bx    = $urandom;
         r.by    = $urandom;
         r.alpha = 16'($urandom);
         r.beta  = 16'($urandom);
      end
      return r;
   endfunction

   task automatic test_directed();
      fix_req_type r;
      int i;
      logic signed [31:0] coords [4] = '{32'sh7FFF_FFFF, -32'sh8000_0000, 32'sd0, 32'sd65536};
      logic [15:0] angles [6] = '{16'd0, 16'd1, 16'd16384, 16'd32768, 16'd49152, 16'hFFFF};
      // coordinate and angle extremes
      for (i = 0; i < 16; i++) begin
         r.ax = coords[i % 4];
         r.ay = coords[(i / 4) % 4];
         r.bx = coords[(i + 1) % 4];
         r.by = coords[(i + 3) % 4];
         r.alpha = angles[i % 6];
         r.beta  = angles[(i + 2) % 6];
         send_fix(r);
      end
      // degenerate baseline, no triangle at exactly pi, wide saturating offset, near-equilateral case
      r = '{32'sd100, -32'sd5, 32'sd100, -32'sd5, 16'd10000, 16'd10000};
      send_fix(r);
      r = '{32'sd0, 32'sd0, 32'sd65536, 32'sd0, 16'd32768, 16'd32768};
      send_fix(r);
      r = '{32'sd0, 32'sd0, 32'sd65536, 32'sd0, 16'd20000, 16'd45536};
      send_fix(r);
      r = '{32'sh7000_0000, 32'sh7000_0000, -32'sh7000_0000, -32'sh7000_0000,
            16'd100, 16'd65000};
      send_fix(r);
      r = '{32'sd0, 32'sd0, 32'sd1000000, 32'sd0, 16'd21845, 16'd21845};
      send_fix(r);
      drain_fixes();
   endtask

   // Hold the receiver off long enough to fill the pipeline and the output buffer
   task automatic test_backpressure();
      int i;
      long_hold = 300;
      for (i = 0; i < 160; i++) send_fix(random_fix(1'b1));
      drain_fixes();
   endtask

   task automatic test_random();
      int i, burst;
      i = 0;
      while (i < 420) begin
         burst = $urandom_range(1, 30);
         repeat (burst) begin
            send_fix(random_fix($urandom_range(0, 3) != 0));
            i++;
         end
         sender_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
      end
      drain_fixes();
   endtask

   // Receiver: long hold when asked, otherwise a stall pattern of its own
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (long_hold > 0) begin
         rsp_chan.ready <= 1'b0;
         long_hold <= long_hold - 1;
      end else begin
         if ($urandom_range(0, 31) == 0) rx_stall_on <= ~rx_stall_on;
         rsp_chan.ready <= rx_stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
      end
   end

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (fix_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result x=%0d y=%0d st=%0d",
                        rsp_chan.point_c_x, rsp_chan.point_c_y, rsp_chan.fix_status);
         end else begin
            want = fix_queue.pop_front();
            if (rsp_chan.point_c_x !== want.point_c_x ||
                rsp_chan.point_c_y !== want.point_c_y ||
                rsp_chan.fix_status !== want.fix_status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: want x=%0d y=%0d st=%0d, got x=%0d y=%0d st=%0d",
                           want.point_c_x, want.point_c_y, want.fix_status,
                           rsp_chan.point_c_x, rsp_chan.point_c_y,
                           rsp_chan.fix_status);
            end
         end
      end
   end

   // Watchdog: count cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      req_chan.valid      <= 1'b0;
      req_chan.point_a_x  <= '0;
      req_chan.point_a_y  <= '0;
      req_chan.point_b_x  <= '0;
      req_chan.point_b_y  <= '0;
      req_chan.angle_at_a <= '0;
      req_chan.angle_at_b <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random();
      repeat (LATENCY + 20) @(posedge clock);
      if (mismatch_count == 0 && fix_queue.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

// File: bearing_triangulation.f
hw/rtl/bt_pkg.sv
hw/rtl/bt_if.sv
hw/rtl/bt_sine.sv
hw/rtl/bt_div.sv
hw/rtl/bearing_triangulation.sv
hw/rtl/bt_checker.sv
bench/bt_tb_if.sv
bench/testbench.sv
